/* rtl/core/qmr_pkg.sv */
package qmr_pkg;

    // Component width and fixed-point format of all quaternion fields.
    localparam int DATA_W = 16;
    localparam int FRAC_W = 14;
    localparam int NUM_C  = 4;

    // Component positions inside a quaternion.
    localparam int COMP_W = 0;
    localparam int COMP_X = 1;
    localparam int COMP_Y = 2;
    localparam int COMP_Z = 3;

    // Mode codes.
    localparam logic FUNC_COMPOSE = 1'b0;
    localparam logic FUNC_ROTATE  = 1'b1;

    // First product v*q: 16x16 products, sum of four, rounded to Q1.14 at full width.
    localparam int P1_W   = 2 * DATA_W;
    localparam int R1_W   = P1_W + 2 - FRAC_W;
    // Second product conj(q)*r: the conjugate needs one extra bit for -(-32768).
    localparam int CONJ_W = DATA_W + 1;
    localparam int P2_W   = CONJ_W + R1_W;
    localparam int R2_W   = P2_W + 2 - FRAC_W;

    // Term k of component c multiplies a[k] by b[c ^ k]; a set bit negates the term.
    localparam logic [NUM_C-1:0] TERM_NEG [NUM_C] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

    typedef logic signed [DATA_W-1:0] comp_t;

    // Clamp a rounded component to the signed 16-bit range.
    function automatic comp_t sat_q14(input logic signed [R2_W-1:0] v);
        logic signed [R2_W-1:0] hi;
        logic signed [R2_W-1:0] lo;
        begin
            hi = R2_W'($signed({1'b0, {(DATA_W-1){1'b1}}}));
            lo = R2_W'($signed({1'b1, {(DATA_W-1){1'b0}}}));
            if (v > hi)
            begin
                sat_q14 = hi[DATA_W-1:0];
            end
            else if (v < lo)
            begin
                sat_q14 = lo[DATA_W-1:0];
            end
            else
            begin
                sat_q14 = v[DATA_W-1:0];
            end
        end
    endfunction

endpackage

/* rtl/core/qmr_if.sv */
// Input channel: mode bit and the two quaternions.
interface qmr_in_if
    import qmr_pkg::*;
();
    logic  valid;
    logic  ready;
    logic  func;
    comp_t q_w;
    comp_t q_x;
    comp_t q_y;
    comp_t q_z;
    comp_t v_w;
    comp_t v_x;
    comp_t v_y;
    comp_t v_z;

    modport source (
        output valid, func, q_w, q_x, q_y, q_z, v_w, v_x, v_y, v_z,
        input  ready
    );
    modport sink (
        input  valid, func, q_w, q_x, q_y, q_z, v_w, v_x, v_y, v_z,
        output ready
    );
endinterface

// Output channel: the result quaternion.
interface qmr_out_if
    import qmr_pkg::*;
();
    logic  valid;
    logic  ready;
    comp_t r_w;
    comp_t r_x;
    comp_t r_y;
    comp_t r_z;

    modport source (
        output valid, r_w, r_x, r_y, r_z,
        input  ready
    );
    modport sink (
        input  valid, r_w, r_x, r_y, r_z,
        output ready
    );
endinterface

/* rtl/core/qmr_mul.sv */
// Registered partial products of a Hamilton product a*b.
// prod_reg[c][k] holds a[k] * b[c ^ k]; the signs are applied in qmr_sum.
module qmr_mul
    import qmr_pkg::*;
#(
    parameter int A_W = DATA_W,
    parameter int B_W = DATA_W
)
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [A_W-1:0]    a [NUM_C],
    input  logic signed [B_W-1:0]    b [NUM_C],
    output logic signed [A_W+B_W-1:0] prod_reg [NUM_C][NUM_C]
);

    localparam int P_W = A_W + B_W;

    // One multiplier per term, sixteen in parallel.
    for (genvar gc = 0; gc < NUM_C; gc++)
    begin : g_comp
        for (genvar gk = 0; gk < NUM_C; gk++)
        begin : g_term
            localparam logic [1:0] BI = 2'(gc) ^ 2'(gk);
            logic signed [P_W-1:0] prod_next;

            assign prod_next = P_W'(a[gk]) * P_W'(b[BI]);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    prod_reg[gc][gk] <= prod_next;
                end
            end
        end
    end

endmodule

/* rtl/core/qmr_sum.sv */
// Signed sum of four products per component, rounded half up to the Q1.14 scale at full width.
module qmr_sum
    import qmr_pkg::*;
#(
    parameter int P_W = P1_W
)
(
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [P_W-1:0]             prod [NUM_C][NUM_C],
    output logic signed [P_W+2-FRAC_W-1:0]    rnd_reg [NUM_C]
);

    localparam int SUM_W = P_W + 2;
    localparam int RND_W = SUM_W - FRAC_W;
    localparam logic signed [SUM_W-1:0] RND_BIAS = SUM_W'(1) <<< (FRAC_W - 1);

    logic signed [RND_W-1:0] rnd_next [NUM_C];

    // Add or subtract each term, then add half an LSB and floor.
    always_comb
    begin
        logic signed [SUM_W-1:0] acc;
        for (int c = 0; c < NUM_C; c++)
        begin
            acc = RND_BIAS;
            for (int k = 0; k < NUM_C; k++)
            begin
                if (TERM_NEG[c][k])
                begin
                    acc = acc - SUM_W'(prod[c][k]);
                end
                else
                begin
                    acc = acc + SUM_W'(prod[c][k]);
                end
            end
            rnd_next[c] = RND_W'(acc >>> FRAC_W);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rnd_reg <= rnd_next;
        end
    end

endmodule

/* rtl/core/quaternion_multiply_rotate.sv */
// Channel | Modport | Beat contents
// cmd     | sink    | func, q_w, q_x, q_y, q_z, v_w, v_x, v_y, v_z
// rsp     | source  | r_w, r_x, r_y, r_z
//
// One beat is accepted per cycle unless a stall on rsp has filled the pipe.
// The pipe is two multiply stages and two sum-and-round stages, plus the output register.
// Reset clears only the stage valid bits; the block keeps no other state.
// A stall on rsp holds the output stage and the run of full stages right behind it.
// A stage with an empty stage ahead still advances, so cmd.ready drops only when all
// five stages are full and rsp.ready is low.
module quaternion_multiply_rotate
    import qmr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    qmr_in_if.sink     cmd,
    qmr_out_if.source  rsp
);

    localparam int NUM_STG = 5;

    // Stage valid bits and per-stage load enables.
    logic [NUM_STG-1:0] vld_reg;
    logic [NUM_STG-1:0] vld_next;
    logic [NUM_STG-1:0] rdy;
    logic [NUM_STG-1:0] prev_vld;

    // Side data carried along the pipe.
    logic                    func1_reg, func2_reg, func3_reg, func4_reg, func5_reg;
    comp_t                   q1_reg [NUM_C];
    comp_t                   q2_reg [NUM_C];
    logic signed [R1_W-1:0]  r1_3_reg [NUM_C];
    logic signed [R1_W-1:0]  r1_4_reg [NUM_C];
    comp_t                   res_reg [NUM_C];
    comp_t                   res_next [NUM_C];

    // Arithmetic datapath signals.
    comp_t                      q_in [NUM_C];
    comp_t                      v_in [NUM_C];
    logic signed [P1_W-1:0]     prod1 [NUM_C][NUM_C];
    logic signed [R1_W-1:0]     rnd1 [NUM_C];
    logic signed [CONJ_W-1:0]   conj_q [NUM_C];
    logic signed [P2_W-1:0]     prod2 [NUM_C][NUM_C];
    logic signed [R2_W-1:0]     rnd2 [NUM_C];

    // A stage may load when it is empty or its content moves on.
    always_comb
    begin
        rdy[NUM_STG-1] = !vld_reg[NUM_STG-1] || rsp.ready;
        for (int i = NUM_STG - 2; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
        prev_vld = {vld_reg[NUM_STG-2:0], cmd.valid};
        for (int i = 0; i < NUM_STG; i++)
        begin
            vld_next[i] = rdy[i] ? prev_vld[i] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign cmd.ready = rdy[0];

    // Input beat as component arrays.
    assign q_in = '{cmd.q_w, cmd.q_x, cmd.q_y, cmd.q_z};
    assign v_in = '{cmd.v_w, cmd.v_x, cmd.v_y, cmd.v_z};

    // Stage 1: partial products of v*q.
    qmr_mul #(
        .A_W (DATA_W),
        .B_W (DATA_W)
    ) u_mul1 (
        .clk      (clk),
        .en       (rdy[0] && prev_vld[0]),
        .a        (v_in),
        .b        (q_in),
        .prod_reg (prod1)
    );

    // Stage 2: v*q summed and rounded at full width.
    qmr_sum #(
        .P_W (P1_W)
    ) u_sum1 (
        .clk     (clk),
        .en      (rdy[1] && prev_vld[1]),
        .prod    (prod1),
        .rnd_reg (rnd1)
    );

    // Conjugate of q, widened so that negating -32768 does not wrap.
    always_comb
    begin
        conj_q[COMP_W] = CONJ_W'(q2_reg[COMP_W]);
        conj_q[COMP_X] = -CONJ_W'(q2_reg[COMP_X]);
        conj_q[COMP_Y] = -CONJ_W'(q2_reg[COMP_Y]);
        conj_q[COMP_Z] = -CONJ_W'(q2_reg[COMP_Z]);
    end

    // Stage 3: partial products of conj(q)*(v*q).
    qmr_mul #(
        .A_W (CONJ_W),
        .B_W (R1_W)
    ) u_mul2 (
        .clk      (clk),
        .en       (rdy[2] && prev_vld[2]),
        .a        (conj_q),
        .b        (rnd1),
        .prod_reg (prod2)
    );

    // Stage 4: second product summed and rounded.
    qmr_sum #(
        .P_W (P2_W)
    ) u_sum2 (
        .clk     (clk),
        .en      (rdy[3] && prev_vld[3]),
        .prod    (prod2),
        .rnd_reg (rnd2)
    );

    // Stage 5 input: pick the result for the mode and saturate; a rotation also zeroes w.
    always_comb
    begin
        for (int c = 0; c < NUM_C; c++)
        begin
            if (func4_reg == FUNC_ROTATE)
            begin
                res_next[c] = sat_q14(rnd2[c]);
            end
            else
            begin
                res_next[c] = sat_q14(R2_W'(r1_4_reg[c]));
            end
        end
        if (func4_reg == FUNC_ROTATE)
        begin
            res_next[COMP_W] = '0;
        end
    end

    // Side data registers, loaded with their stage.
    always_ff @(posedge clk)
    begin
        if (rdy[0] && prev_vld[0])
        begin
            func1_reg <= cmd.func;
            q1_reg    <= q_in;
        end
        if (rdy[1] && prev_vld[1])
        begin
            func2_reg <= func1_reg;
            q2_reg    <= q1_reg;
        end
        if (rdy[2] && prev_vld[2])
        begin
            func3_reg <= func2_reg;
            r1_3_reg  <= rnd1;
        end
        if (rdy[3] && prev_vld[3])
        begin
            func4_reg <= func3_reg;
            r1_4_reg  <= r1_3_reg;
        end
        if (rdy[4] && prev_vld[4])
        begin
            func5_reg <= func4_reg;
            res_reg   <= res_next;
        end
    end

    assign rsp.valid = vld_reg[NUM_STG-1];
    assign rsp.r_w   = res_reg[COMP_W];
    assign rsp.r_x   = res_reg[COMP_X];
    assign rsp.r_y   = res_reg[COMP_Y];
    assign rsp.r_z   = res_reg[COMP_Z];

    // A rotate result always leaves with a zero w component.
    a_rotate_w_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[NUM_STG-1] && func5_reg == FUNC_ROTATE) |-> (rsp.r_w == '0))
        else $error("rotate result with nonzero w");

    // An accepted beat always lands in the first stage.
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> vld_reg[0])
        else $error("accepted beat lost at stage 1");

    // A full pipe under a stalled output takes no new beat.
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (&vld_reg && !rsp.ready) |-> !cmd.ready)
        else $error("beat accepted into a full stalled pipe");

    // Stage 4, blocked downstream, keeps its beat.
    a_stage4_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[3] && !rdy[4]) |=> vld_reg[3])
        else $error("stage 4 beat dropped during stall");

endmodule

/* dv/tb.sv */
module tb;
    import qmr_pkg::*;

    // One command beat and one result beat, as carried by the two channels.
    typedef struct {
        logic  func;
        comp_t q_w;
        comp_t q_x;
        comp_t q_y;
        comp_t q_z;
        comp_t v_w;
        comp_t v_x;
        comp_t v_y;
        comp_t v_z;
    } cmd_beat_t;

    typedef struct {
        comp_t r_w;
        comp_t r_x;
        comp_t r_y;
        comp_t r_z;
    } rsp_beat_t;

    // Quaternion held at full precision while the products are formed.
    typedef struct {
        longint w;
        longint x;
        longint y;
        longint z;
    } quat_t;

    // Predicts each result from its command beat and checks results in order.
    class quat_scoreboard;
        rsp_beat_t expected_results[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        // Q2.28 sum back to Q1.14, rounding half up.
        static function longint round_half_up(longint s);
            return (s + 64'sd8192) >>> FRAC_W;
        endfunction

        static function comp_t clamp16(longint v);
            if (v > 32767)
            begin
                return comp_t'(32767);
            end
            if (v < -32768)
            begin
                return comp_t'(-32768);
            end
            return comp_t'(v);
        endfunction

        // Hamilton product a*b with every component rounded but not clamped.
        static function quat_t hamilton(quat_t a, quat_t b);
            quat_t r;
            r.w = round_half_up(a.w * b.w - a.x * b.x - a.y * b.y - a.z * b.z);
            r.x = round_half_up(a.w * b.x + a.x * b.w + a.y * b.z - a.z * b.y);
            r.y = round_half_up(a.w * b.y - a.x * b.z + a.y * b.w + a.z * b.x);
            r.z = round_half_up(a.w * b.z + a.x * b.y - a.y * b.x + a.z * b.w);
            return r;
        endfunction

        function rsp_beat_t predict_result(cmd_beat_t b);
            quat_t     q;
            quat_t     v;
            quat_t     conj_q;
            quat_t     prod;
            rsp_beat_t r;
            q.w = b.q_w;
            q.x = b.q_x;
            q.y = b.q_y;
            q.z = b.q_z;
            v.w = b.v_w;
            v.x = b.v_x;
            v.y = b.v_y;
            v.z = b.v_z;
            prod = hamilton(v, q);
            // Rotation: the conjugate is negated at full width, so -32768 becomes +32768.
            if (b.func == FUNC_ROTATE)
            begin
                conj_q.w = q.w;
                conj_q.x = -q.x;
                conj_q.y = -q.y;
                conj_q.z = -q.z;
                prod = hamilton(conj_q, prod);
                prod.w = 0;
            end
            r.r_w = clamp16(prod.w);
            r.r_x = clamp16(prod.x);
            r.r_y = clamp16(prod.y);
            r.r_z = clamp16(prod.z);
            return r;
        endfunction

        function void note_cmd(cmd_beat_t b);
            expected_results.push_back(predict_result(b));
        endfunction

        function void check_field(string name, comp_t want, comp_t got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_rsp(rsp_beat_t got);
            rsp_beat_t want;
            if (expected_results.size() == 0)
            begin
                $error("result beat with no command outstanding: %0d %0d %0d %0d",
                       got.r_w, got.r_x, got.r_y, got.r_z);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            check_field("r_w", want.r_w, got.r_w);
            check_field("r_x", want.r_x, got.r_x);
            check_field("r_y", want.r_y, got.r_y);
            check_field("r_z", want.r_z, got.r_z);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   tx_idle_pct;
    int   rx_idle_pct;

    qmr_in_if  cmd_if();
    qmr_out_if rsp_if();

    quat_scoreboard sb;

    quaternion_multiply_rotate u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Overall time limit for the run.
    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    // Result side: ready drops at random according to the current idle rate.
    initial
    begin
        forever
        begin
            @(negedge clk);
            rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Note every accepted command beat and check every accepted result beat.
    always @(posedge clk)
    begin : beat_monitor
        cmd_beat_t cb;
        rsp_beat_t rb;
        if (rst_n && cmd_if.valid && cmd_if.ready)
        begin
            cb.func = cmd_if.func;
            cb.q_w  = cmd_if.q_w;
            cb.q_x  = cmd_if.q_x;
            cb.q_y  = cmd_if.q_y;
            cb.q_z  = cmd_if.q_z;
            cb.v_w  = cmd_if.v_w;
            cb.v_x  = cmd_if.v_x;
            cb.v_y  = cmd_if.v_y;
            cb.v_z  = cmd_if.v_z;
            sb.note_cmd(cb);
        end
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            rb.r_w = rsp_if.r_w;
            rb.r_x = rsp_if.r_x;
            rb.r_y = rsp_if.r_y;
            rb.r_z = rsp_if.r_z;
            sb.check_rsp(rb);
        end
    end

    function automatic cmd_beat_t make_beat(logic f, int qw, int qx, int qy, int qz,
                                            int vw, int vx, int vy, int vz);
        cmd_beat_t b;
        b.func = f;
        b.q_w  = comp_t'(qw);
        b.q_x  = comp_t'(qx);
        b.q_y  = comp_t'(qy);
        b.q_z  = comp_t'(qz);
        b.v_w  = comp_t'(vw);
        b.v_x  = comp_t'(vx);
        b.v_y  = comp_t'(vy);
        b.v_z  = comp_t'(vz);
        return b;
    endfunction

    // Component mix: full range, the unit-quaternion range, and corner values.
    function automatic comp_t rand_comp();
        case ($urandom_range(3))
            0, 1:    return comp_t'($urandom);
            2:       return comp_t'(int'($urandom_range(32768)) - 16384);
            default:
            begin
                case ($urandom_range(7))
                    0:       return comp_t'(-32768);
                    1:       return comp_t'(-32767);
                    2:       return comp_t'(-1);
                    3:       return comp_t'(0);
                    4:       return comp_t'(1);
                    5:       return comp_t'(16384);
                    6:       return comp_t'(-16384);
                    default: return comp_t'(32767);
                endcase
            end
        endcase
    endfunction

    function automatic cmd_beat_t rand_beat();
        cmd_beat_t b;
        b.func = $urandom_range(1) ? FUNC_ROTATE : FUNC_COMPOSE;
        b.q_w  = rand_comp();
        b.q_x  = rand_comp();
        b.q_y  = rand_comp();
        b.q_z  = rand_comp();
        b.v_w  = rand_comp();
        b.v_x  = rand_comp();
        b.v_y  = rand_comp();
        b.v_z  = rand_comp();
        return b;
    endfunction

    // Drive one command beat, with random idle cycles first, and wait for acceptance.
    task automatic send_item(input cmd_beat_t b);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            cmd_if.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.func  <= b.func;
        cmd_if.q_w   <= b.q_w;
        cmd_if.q_x   <= b.q_x;
        cmd_if.q_y   <= b.q_y;
        cmd_if.q_z   <= b.q_z;
        cmd_if.v_w   <= b.v_w;
        cmd_if.v_x   <= b.v_x;
        cmd_if.v_y   <= b.v_y;
        cmd_if.v_z   <= b.v_z;
        @(posedge clk);
        while (!cmd_if.ready)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin : stimulus
        logic f;
        sb = new();
        rst_n        = 1'b0;
        tx_idle_pct  = 8;
        rx_idle_pct  = 75;
        cmd_if.valid = 1'b0;
        cmd_if.func  = FUNC_COMPOSE;
        cmd_if.q_w   = '0;
        cmd_if.q_x   = '0;
        cmd_if.q_y   = '0;
        cmd_if.q_z   = '0;
        cmd_if.v_w   = '0;
        cmd_if.v_x   = '0;
        cmd_if.v_y   = '0;
        cmd_if.v_z   = '0;
        rsp_if.ready = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed cases in both modes: zero, identity, both extremes, the conjugate
        // of the most negative value, and a large unclamped intermediate product.
        for (int i = 0; i < 2; i++)
        begin
            f = (i == 0) ? FUNC_COMPOSE : FUNC_ROTATE;
            send_item(make_beat(f, 0, 0, 0, 0, 0, 0, 0, 0));
            send_item(make_beat(f, 16384, 0, 0, 0, 1000, 2000, -3000, 4000));
            send_item(make_beat(f, 32767, 32767, 32767, 32767,
                                32767, 32767, 32767, 32767));
            send_item(make_beat(f, -32768, -32768, -32768, -32768,
                                -32768, -32768, -32768, -32768));
            send_item(make_beat(f, 32767, -32768, 32767, -32768,
                                -32768, 32767, -32768, 32767));
            send_item(make_beat(f, 0, -32768, -32768, -32768, 12345, 16384, -16384, 8191));
            send_item(make_beat(f, 23170, 23170, 23170, 23170,
                                32767, 32767, -32768, 32767));
        end
        // Rounding at exactly one half, on both signs, and just below one half.
        send_item(make_beat(FUNC_COMPOSE, 1, 0, 0, 0, 8192, 0, 0, 0));
        send_item(make_beat(FUNC_COMPOSE, 1, 0, 0, 0, -8192, 0, 0, 0));
        send_item(make_beat(FUNC_COMPOSE, 1, 0, 0, 0, 8191, 0, 0, 0));

        // Random beats in three idle settings.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_idle_pct = 8;
                    rx_idle_pct = 75;
                end
                1:
                begin
                    tx_idle_pct = 75;
                    rx_idle_pct = 8;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < 500; n++)
            begin
                send_item(rand_beat());
            end
        end
        @(negedge clk);
        cmd_if.valid <= 1'b0;

        // Drain, then keep watching for any stray result beat before the verdict.
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
